[hdl/bmalu_pkg.sv]
// bmalu_pkg: shared types and constants for the 64-bit bit-manipulation unit
// no dependencies; imported by every module of the block
package bmalu_pkg;

   localparam int DATA_W = 64;
   localparam int CMD_W  = 5;
   localparam int CNT_W  = 7;
   localparam int SH_W   = 6;

   localparam logic [DATA_W-1:0] MASK_1 = 64'h5555555555555555;
   localparam logic [DATA_W-1:0] MASK_2 = 64'h3333333333333333;
   localparam logic [DATA_W-1:0] MASK_4 = 64'h0F0F0F0F0F0F0F0F;

   typedef enum logic [CMD_W-1:0] {
      CMD_AND    = 5'd0,
      CMD_OR     = 5'd1,
      CMD_XOR    = 5'd2,
      CMD_NOT    = 5'd3,
      CMD_SHL    = 5'd4,
      CMD_SAR    = 5'd5,
      CMD_SHR    = 5'd6,
      CMD_ROTL   = 5'd7,
      CMD_ROTR   = 5'd8,
      CMD_POPCNT = 5'd9,
      CMD_CLZ    = 5'd10,
      CMD_CTZ    = 5'd11,
      CMD_BITREV = 5'd12,
      CMD_BSWAP  = 5'd13,
      CMD_GET    = 5'd14,
      CMD_SET    = 5'd15,
      CMD_CLEAR  = 5'd16,
      CMD_TOGGLE = 5'd17
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] popcnt;
      logic [CNT_W-1:0] clz;
      logic [CNT_W-1:0] ctz;
   } cnt_type;

endpackage

[hdl/bmalu_count.sv]
// bmalu_count: population count, leading and trailing zero count of one word
// depends on bmalu_pkg
module bmalu_count (
   input  logic [bmalu_pkg::DATA_W-1:0] value,
   output bmalu_pkg::cnt_type           counts
);
   import bmalu_pkg::*;

   logic [DATA_W-1:0] pc_1;
   logic [DATA_W-1:0] pc_2;
   logic [DATA_W-1:0] pc_3;
   logic [CNT_W-1:0]  pc_sum;
   logic [DATA_W-1:0] rev;

   function automatic logic [CNT_W-1:0] lead_zero(input logic [DATA_W-1:0] u);
      logic [DATA_W-1:0] x;
      logic [CNT_W-1:0]  n;
      x = u;
      n = '0;
      if (x[63:32] == '0) begin n = n + CNT_W'(32); x = x << 32; end
      if (x[63:48] == '0) begin n = n + CNT_W'(16); x = x << 16; end
      if (x[63:56] == '0) begin n = n + CNT_W'(8);  x = x << 8;  end
      if (x[63:60] == '0) begin n = n + CNT_W'(4);  x = x << 4;  end
      if (x[63:62] == '0) begin n = n + CNT_W'(2);  x = x << 2;  end
      if (x[63] == 1'b0) begin n = n + CNT_W'(1); end
      if (u == '0) begin n = CNT_W'(DATA_W); end
      return n;
   endfunction

   // swar partial sums, then add the eight byte counts
   always_comb begin
      pc_1   = value - ((value >> 1) & MASK_1);
      pc_2   = (pc_1 & MASK_2) + ((pc_1 >> 2) & MASK_2);
      pc_3   = (pc_2 + (pc_2 >> 4)) & MASK_4;
      pc_sum = '0;
      for (int i = 0; i < DATA_W / 8; i++) begin
         pc_sum = pc_sum + CNT_W'(pc_3[i*8 +: 4]);
      end
   end

   assign rev = {<<{value}};

   assign counts.popcnt = pc_sum;
   assign counts.clz    = lead_zero(value);
   assign counts.ctz    = lead_zero(rev);

endmodule

[hdl/bmalu_exec.sv]
// bmalu_exec: operation decode and result select for one request
// depends on bmalu_pkg and bmalu_count
module bmalu_exec (
   input  bmalu_pkg::cmd_type            command,
   input  logic [bmalu_pkg::DATA_W-1:0]  operand_a,
   input  logic [bmalu_pkg::DATA_W-1:0]  operand_b,
   output logic [bmalu_pkg::DATA_W-1:0]  result
);
   import bmalu_pkg::*;

   cnt_type           counts;
   logic [SH_W-1:0]   sh;
   logic [SH_W:0]     sh_inv;
   logic              in_range;
   logic [DATA_W-1:0] bit_mask;
   logic [DATA_W-1:0] shl_val;
   logic [DATA_W-1:0] shr_val;

   bmalu_count u_count (
      .value  (operand_a),
      .counts (counts)
   );

   assign sh       = operand_b[SH_W-1:0];
   assign sh_inv   = (SH_W+1)'(DATA_W) - {1'b0, sh};
   assign in_range = (operand_b[DATA_W-1:SH_W] == '0);
   assign bit_mask = DATA_W'(1) << sh;
   assign shl_val  = operand_a << sh;
   assign shr_val  = operand_a >> sh;

   always_comb begin
      case (command)
         CMD_AND:    result = operand_a & operand_b;
         CMD_OR:     result = operand_a | operand_b;
         CMD_XOR:    result = operand_a ^ operand_b;
         CMD_NOT:    result = ~operand_a;
         CMD_SHL:    result = in_range ? shl_val : '0;
         CMD_SAR: begin
            if (operand_b[DATA_W-1]) begin
               result = operand_a;
            end else if (!in_range) begin
               result = {DATA_W{operand_a[DATA_W-1]}};
            end else begin
               result = DATA_W'($signed(operand_a) >>> sh);
            end
         end
         CMD_SHR:    result = in_range ? shr_val : '0;
         CMD_ROTL:   result = shl_val | (operand_a >> sh_inv);
         CMD_ROTR:   result = shr_val | (operand_a << sh_inv);
         CMD_POPCNT: result = DATA_W'(counts.popcnt);
         CMD_CLZ:    result = DATA_W'(counts.clz);
         CMD_CTZ:    result = DATA_W'(counts.ctz);
         CMD_BITREV: result = {<<{operand_a}};
         CMD_BSWAP:  result = {<<8{operand_a}};
         CMD_GET:    result = in_range ? DATA_W'(shr_val[0]) : '0;
         CMD_SET:    result = in_range ? (operand_a | bit_mask) : operand_a;
         CMD_CLEAR:  result = in_range ? (operand_a & ~bit_mask) : operand_a;
         CMD_TOGGLE: result = in_range ? (operand_a ^ bit_mask) : operand_a;
         default:    result = '0;
      endcase
   end

endmodule

[hdl/bit_manipulation_alu_64.sv]
// bit_manipulation_alu_64: top level, request register, execute logic, result register
// depends on bmalu_pkg and bmalu_exec
//
//   channel  direction  tdata                              tuser
//   req_     in         operand_a [63:0], operand_b [127:64]  command [4:0]
//   rsp_     out        result [63:0]                      -
//
// two register stages: rsp_tvalid rises as the result register loads; one request per cycle
// unless stalled, a rate set by the single pass through bmalu_exec between the two registers
// reset clears both valid flags; data registers are not reset
// a stalled result holds in the output register while one more request waits
// in the request register; req_tready drops only when both are full
module bit_manipulation_alu_64 (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a, operand_b
   input  logic [4:0]   req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata    // result
);
   import bmalu_pkg::*;

   logic              req_valid_ff;
   logic              req_valid_in;
   cmd_type           cmd_ff;
   logic [DATA_W-1:0] a_ff;
   logic [DATA_W-1:0] b_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] result_ff;
   logic [DATA_W-1:0] result_in;
   logic              rsp_load;
   logic              req_load;

   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign req_load     = !req_valid_ff || rsp_load;
   assign req_tready   = req_load;
   assign req_valid_in = req_load ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;

   bmalu_exec u_exec (
      .command   (cmd_ff),
      .operand_a (a_ff),
      .operand_b (b_ff),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_tvalid) begin
         cmd_ff <= cmd_type'(req_tuser);
         a_ff   <= req_tdata[DATA_W-1:0];
         b_ff   <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (rsp_load && req_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

endmodule

[hdl/bmalu_checker.sv]
// bmalu_checker: port-level checks for bit_manipulation_alu_64, bound to the top level
// depends on bmalu_pkg
module bmalu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [4:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);
   import bmalu_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // request stalls only while a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a blocked result");

   // an accepted request reaches the output through the result register when not blocked
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped or changed while stalled");

   // a waiting request is held unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=>
         (req_tvalid && $stable(req_tdata) && $stable(req_tuser)))
      else $error("request dropped or changed while waiting");

endmodule

bind bit_manipulation_alu_64 bmalu_checker u_bmalu_checker (.*);
